// File: rtl/core/iqfsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iqfsm_pkg: shared constants and sine table for the I/Q frequency shift mixer
// Holds the stream and register layout, the quadrant codes and the
// quarter-wave sine table, built at elaboration in Q30 fixed point.
// ----------------------------------------------------------------------------
package iqfsm_pkg;

    localparam int TABLE_ADDR_BITS = 10;
    localparam int TAB_N           = 1 << TABLE_ADDR_BITS;
    localparam int SINE_BITS       = 15;
    localparam int SAMPLE_BITS     = 8;
    localparam int INDEX_BITS      = 32;
    localparam int PHASE_BITS      = 32;
    localparam int OUT_BITS        = 17;
    localparam int PROD_BITS       = SAMPLE_BITS + SINE_BITS + 1;
    localparam int SCALE_SHIFT     = 7;

    localparam int IN_TDATA_BITS   = 48;
    localparam int OUT_TDATA_BITS  = 40;
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;

    // Register index taken from paddr bit 2 (registers on 4-byte spacing)
    localparam logic REG_PHASE_STEP = 1'b0;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int            Q30_SHIFT   = 30;
    localparam logic [63:0]   Q30_ONE     = 64'd1073741824;
    localparam logic [63:0]   HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0]   SINE_SCALE  = 64'd32767;
    localparam logic [63:0]   Q30_HALF    = 64'd536870912;
    localparam int            TAYLOR_TERMS = 11;

    // (2n)(2n+1) for n from 11 down to 1
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd506, 64'd420, 64'd342, 64'd272, 64'd210, 64'd156,
        64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    typedef logic [SINE_BITS-1:0] sine_tab_t [0:TAB_N];

    function automatic logic [SINE_BITS-1:0] sine_entry(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] e;
        x  = (k * HALF_PI_Q30 + 64'(TAB_N >> 1)) >> TABLE_ADDR_BITS;
        x2 = (x * x) >> Q30_SHIFT;
        t  = Q30_ONE;
        for (int j = 0; j < TAYLOR_TERMS; j++) begin
            p = (x2 * t) >> Q30_SHIFT;
            t = Q30_ONE - p / TAYLOR_DIV[j];
        end
        s = (x * t) >> Q30_SHIFT;
        e = (s * SINE_SCALE + Q30_HALF) >> Q30_SHIFT;
        return e[SINE_BITS-1:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int k = 0; k <= TAB_N; k++) begin
            tab[k] = sine_entry(64'(k));
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/iq_frequency_shift_mixer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iq_frequency_shift_mixer_unit: NCO and complex mixer
// Rotates each I/Q sample by phase = sample_index * phase_step (mod 2^32),
// using a quarter-wave sine ROM, and scales the product by 1/128.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per sample. tdata[7:0] i_sample, [15:8] q_sample,
//           [47:16] sample_index.
//   m_axis: one beat per sample. tdata[16:0] i_shifted, [33:17] q_shifted,
//           [39:34] zero.
//   APB:    phase_step at byte address 0; write it only while the block is
//           empty. Reads return the current value.
// One beat is accepted per cycle unless an m_axis_tready stall has filled the pipe:
// the 32x32 phase product, the two ROM reads, the four 8x16 products and the
// final add each sit in their own register stage.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up and input beats keep flowing into
// empty stages while an output beat waits for m_axis_tready.
// Reset clears all valid bits and sets phase_step to zero; the ROM is a
// constant and needs no fill.
// ----------------------------------------------------------------------------
module iq_frequency_shift_mixer_unit
    import iqfsm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // APB configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [APB_DATA_BITS-1:0]   pwdata,
    output      logic [APB_DATA_BITS-1:0]   prdata,
    output      logic                       pready,
    // input stream
    input  wire logic                       s_axis_tvalid,
    output      logic                       s_axis_tready,
    input  wire logic [IN_TDATA_BITS-1:0]   s_axis_tdata,  // i_sample, q_sample, sample_index
    // output stream
    output      logic                       m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output      logic [OUT_TDATA_BITS-1:0]  m_axis_tdata   // i_shifted, q_shifted, zero pad
);

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    // configuration
    logic signed [PHASE_BITS-1:0] phase_step_reg;
    logic                         cfg_wr;

    // stage enables
    logic en1, en2, en3, en4;

    // stage 1: phase
    logic                           v1_reg;
    logic [PHASE_BITS-1:0]          phase_reg;
    logic signed [SAMPLE_BITS-1:0]  i1_reg, q1_reg;
    logic [PHASE_BITS-1:0]          phase_next;

    // stage 2: table reads
    logic                           v2_reg;
    logic [SINE_BITS-1:0]           sin2_reg, cos2_reg;
    logic [1:0]                     quad2_reg;
    logic signed [SAMPLE_BITS-1:0]  i2_reg, q2_reg;
    logic [TABLE_ADDR_BITS-1:0]     addr_s;
    logic [TABLE_ADDR_BITS:0]       addr_c;

    // stage 3: products
    logic                           v3_reg;
    logic signed [PROD_BITS-1:0]    ic_reg, qs_reg, is_reg, qc_reg;
    logic signed [SINE_BITS:0]      cv, sv, s_pos, c_pos;

    // stage 4: output
    logic                           v4_reg;
    logic signed [OUT_BITS-1:0]     i_out_reg, q_out_reg;
    logic signed [PROD_BITS:0]      re_sum, im_sum;

    // ------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PHASE_STEP);

    always_comb
    begin
        if (paddr[2] == REG_PHASE_STEP)
            prdata = phase_step_reg;
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_step_reg <= '0;
        else if (cfg_wr)
            phase_step_reg <= pwdata;
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage moves when the next one is empty or moving
    // ------------------------------------------------------------------
    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: phase = index * step, low 32 bits
    // ------------------------------------------------------------------
    assign phase_next = PHASE_BITS'(s_axis_tdata[47:16] * unsigned'(phase_step_reg));

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            phase_reg <= phase_next;
            i1_reg    <= s_axis_tdata[7:0];
            q1_reg    <= s_axis_tdata[15:8];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sine ROM, two read ports
    // ------------------------------------------------------------------
    assign addr_s = phase_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign addr_c = (TABLE_ADDR_BITS+1)'(TAB_N) - {1'b0, addr_s};

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            sin2_reg  <= SINE_TAB[addr_s];
            cos2_reg  <= SINE_TAB[addr_c];
            quad2_reg <= phase_reg[PHASE_BITS-1 -: 2];
            i2_reg    <= i1_reg;
            q2_reg    <= q1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: fold the quadrant, then the four products
    // ------------------------------------------------------------------
    assign s_pos = signed'({1'b0, sin2_reg});
    assign c_pos = signed'({1'b0, cos2_reg});

    always_comb
    begin
        unique case (quad2_reg)
            QUAD_0:
            begin
                cv = c_pos;
                sv = s_pos;
            end
            QUAD_1:
            begin
                cv = -s_pos;
                sv = c_pos;
            end
            QUAD_2:
            begin
                cv = -c_pos;
                sv = -s_pos;
            end
            QUAD_3:
            begin
                cv = s_pos;
                sv = -c_pos;
            end
            default:
            begin
                cv = c_pos;
                sv = s_pos;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            ic_reg <= PROD_BITS'(i2_reg * cv);
            qs_reg <= PROD_BITS'(q2_reg * sv);
            is_reg <= PROD_BITS'(i2_reg * sv);
            qc_reg <= PROD_BITS'(q2_reg * cv);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sum and floor-divide by 128
    // ------------------------------------------------------------------
    assign re_sum = {ic_reg[PROD_BITS-1], ic_reg} - {qs_reg[PROD_BITS-1], qs_reg};
    assign im_sum = {is_reg[PROD_BITS-1], is_reg} + {qc_reg[PROD_BITS-1], qc_reg};

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            i_out_reg <= re_sum[SCALE_SHIFT+OUT_BITS-1:SCALE_SHIFT];
            q_out_reg <= im_sum[SCALE_SHIFT+OUT_BITS-1:SCALE_SHIFT];
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {(OUT_TDATA_BITS-2*OUT_BITS)'(0), q_out_reg, i_out_reg};

endmodule
`default_nettype wire

// File: tb/tb_iq_frequency_shift_mixer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_iq_frequency_shift_mixer_unit: stream test of the NCO and complex mixer
// Drives I/Q samples with their sample index through s_axis and predicts each
// rotated sample from a local quarter-wave table and modular phase product.
// Checks every m_axis beat in order against the prediction. Also covers the
// phase_step register over its extremes, with bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_iq_frequency_shift_mixer_unit
    import iqfsm_pkg::*;
();

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          SETTLE_TICKS = 8;
    localparam int          PHASE_ITEMS  = 200;
    localparam logic [63:0] Q30_UNIT     = 64'd1073741824;
    localparam logic [63:0] Q30_QUARTER  = 64'd1686629713;
    localparam logic [63:0] Q30_ROUND    = 64'd536870912;

    // Receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_BURSTY   = 2;
    localparam int RX_PERIODIC = 3;

    typedef struct {
        logic [31:0]        idx;
        logic signed [7:0]  i_in;
        logic signed [7:0]  q_in;
        logic signed [16:0] i_out;
        logic signed [16:0] q_out;
    } rotated_sample_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       psel          = 1'b0;
    logic                       penable       = 1'b0;
    logic                       pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0]   paddr         = '0;
    logic [APB_DATA_BITS-1:0]   pwdata        = '0;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_BITS-1:0]   s_axis_tdata  = '0;  // i_sample, q_sample, sample_index
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;        // i_shifted, q_shifted, zero pad

    int              quarter_wave [0:TAB_N];
    logic [31:0]     cur_step = '0;
    rotated_sample_t pending_results [$];
    int              mismatch_count  = 0;
    int              results_checked = 0;
    int              samples_sent    = 0;
    int              step_settings   = 0;
    int              cycle_count     = 0;
    int              rx_mode         = RX_ALWAYS;
    int              rx_stall_left   = 0;
    int              rx_tick         = 0;

    iq_frequency_shift_mixer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Quarter-wave sine point in Q0.15, Q30 Taylor series with truncated products
    function automatic int sine_point(input longint unsigned k);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned acc;
        longint unsigned prod;
        longint unsigned s;
        longint unsigned n;
        ang  = (k * Q30_QUARTER + 64'(TAB_N / 2)) >> TABLE_ADDR_BITS;
        ang2 = (ang * ang) >> 30;
        acc  = Q30_UNIT;
        for (n = 11; n >= 1; n--)
        begin
            prod = (ang2 * acc) >> 30;
            acc  = Q30_UNIT - prod / ((2 * n) * (2 * n + 1));
        end
        s = (ang * acc) >> 30;
        return int'((s * 64'd32767 + Q30_ROUND) >> 30);
    endfunction

    function automatic rotated_sample_t rotate_sample(input logic signed [7:0] i_s,
                                                      input logic signed [7:0] q_s,
                                                      input logic [31:0] idx,
                                                      input logic [31:0] step);
        logic [31:0]     phase;
        int              addr;
        int              s_v;
        int              c_v;
        int              cs;
        int              sn;
        longint          re;
        longint          im;
        rotated_sample_t r;
        phase = idx * step;
        addr  = int'(phase[29 -: TABLE_ADDR_BITS]);
        s_v   = quarter_wave[addr];
        c_v   = quarter_wave[TAB_N - addr];
        case (phase[31:30])
            QUAD_0:  begin cs = c_v;  sn = s_v;  end
            QUAD_1:  begin cs = -s_v; sn = c_v;  end
            QUAD_2:  begin cs = -c_v; sn = -s_v; end
            default: begin cs = s_v;  sn = -c_v; end
        endcase
        re      = longint'(i_s) * cs - longint'(q_s) * sn;
        im      = longint'(i_s) * sn + longint'(q_s) * cs;
        r.idx   = idx;
        r.i_in  = i_s;
        r.q_in  = q_s;
        r.i_out = 17'(re >>> 7);
        r.q_out = 17'(im >>> 7);
        return r;
    endfunction

    task automatic flag_mismatch(input string detail);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("MISMATCH: %s", detail);
        end
    endtask

    // Write phase_step, then read it back; psel stays high between the two
    task automatic set_phase_step(input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PHASE_STEP, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel     <= 1'b0;
        penable  <= 1'b0;
        @(posedge clk);
        cur_step = value;
        step_settings++;
        if (readback !== value)
        begin
            flag_mismatch($sformatf("phase_step readback exp %h got %h", value, readback));
        end
    endtask

    task automatic send_sample(input logic signed [7:0] i_s, input logic signed [7:0] q_s,
                               input logic [31:0] idx);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, q_s, i_s};
        do @(posedge clk); while (!s_axis_tready);
        pending_results = {pending_results, rotate_sample(i_s, q_s, idx, cur_step)};
        samples_sent++;
    endtask

    // Hold the input until every predicted beat is out, then let the pipe settle
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_COIN:
                m_axis_tready <= 1'($urandom);
            RX_BURSTY:
                if (rx_stall_left > 0)
                begin
                    rx_stall_left <= rx_stall_left - 1;
                    m_axis_tready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    rx_stall_left <= $urandom_range(1, 20);
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            RX_PERIODIC:
                m_axis_tready <= (rx_tick % 7) >= 3;
            default:
                m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin : check_results
        rotated_sample_t    want;
        logic signed [16:0] got_i;
        logic signed [16:0] got_q;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            got_i = m_axis_tdata[16:0];
            got_q = m_axis_tdata[33:17];
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected beat i %0d q %0d", got_i, got_q));
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got_i !== want.i_out)
                begin
                    flag_mismatch($sformatf("idx %h in (%0d,%0d): i_shifted exp %0d got %0d",
                                            want.idx, want.i_in, want.q_in, want.i_out, got_i));
                end
                if (got_q !== want.q_out)
                begin
                    flag_mismatch($sformatf("idx %h in (%0d,%0d): q_shifted exp %0d got %0d",
                                            want.idx, want.i_in, want.q_in, want.q_out, got_q));
                end
                if (m_axis_tdata[OUT_TDATA_BITS-1:34] !== '0)
                begin
                    flag_mismatch($sformatf("idx %h: pad bits %b not zero",
                                            want.idx, m_axis_tdata[OUT_TDATA_BITS-1:34]));
                end
            end
        end
    end

    // Reset value of phase_step is zero: every sample sees phase 0
    task automatic test_register_reset();
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_PHASE_STEP, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel     <= 1'b0;
        penable  <= 1'b0;
        @(posedge clk);
        if (readback !== 32'h0)
        begin
            flag_mismatch($sformatf("phase_step after reset exp 0 got %h", readback));
        end
        send_sample(8'sd127, -8'sd128, 32'hFFFF_FFFF);
        send_sample(-8'sd128, 8'sd127, 32'h1234_5678);
        drain_pipeline();
    endtask

    // With phase_step 1 the index is the phase: hit each quadrant and table end
    task automatic test_quadrant_corners();
        set_phase_step(32'h0000_0001);
        send_sample(8'sd127, 8'sd127, 32'h0000_0000);
        send_sample(-8'sd128, -8'sd128, 32'h0000_0000);
        send_sample(-8'sd128, 8'sd127, 32'h4000_0000);
        send_sample(8'sd127, -8'sd128, 32'h8000_0000);
        send_sample(-8'sd128, -8'sd128, 32'hC000_0000);
        send_sample(8'sd127, 8'sd0, 32'h3FF0_0000);
        send_sample(-8'sd1, -8'sd1, 32'h3FFF_FFFF);
        send_sample(8'sd0, 8'sd0, 32'hFFFF_FFFF);
        send_sample(8'sd1, -8'sd1, 32'h0010_0000);
        send_sample(-8'sd128, 8'sd127, 32'h7FFF_FFFF);
        send_sample(8'sd127, -8'sd128, 32'hBFF0_0000);
        send_sample(-8'sd128, -8'sd128, 32'hFFF0_0000);
        send_sample(8'sd127, 8'sd127, 32'h000F_FFFF);
        drain_pipeline();
    endtask

    // Index times step wraps modulo 2^32
    task automatic test_product_wrap();
        set_phase_step(32'hFFFF_FFFF);
        send_sample(8'sd127, -8'sd128, 32'h0000_0001);
        send_sample(-8'sd128, 8'sd127, 32'hFFFF_FFFF);
        drain_pipeline();
        set_phase_step(32'h8000_0000);
        send_sample(8'sd127, 8'sd127, 32'h0000_0003);
        send_sample(-8'sd128, -8'sd128, 32'h0000_0002);
        drain_pipeline();
        set_phase_step(32'h7FFF_FFFF);
        send_sample(-8'sd128, 8'sd127, 32'hFFFF_FFFF);
        send_sample(8'sd127, -8'sd1, 32'h8000_0000);
        drain_pipeline();
    endtask

    task automatic run_random_phase(input logic [31:0] step, input int rx_pattern,
                                    input bit bursty, input bit hold_midway,
                                    input bit sequential, input logic [31:0] first_idx);
        int                sent;
        int                burst;
        int                gap;
        logic [31:0]       idx;
        logic signed [7:0] iv;
        logic signed [7:0] qv;
        set_phase_step(step);
        rx_mode = rx_pattern;
        idx     = first_idx;
        sent    = 0;
        while (sent < PHASE_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < PHASE_ITEMS)
            begin
                iv = pick_sample();
                qv = pick_sample();
                if (!sequential)
                begin
                    idx = $urandom;
                end
                send_sample(iv, qv, idx);
                idx++;
                sent++;
                burst--;
                if (hold_midway && sent == PHASE_ITEMS / 2)
                begin
                    drain_pipeline();
                end
            end
            if (bursty)
            begin
                gap = $urandom_range(0, 12);
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        run_random_phase(32'h7FFF_FFFF, RX_COIN, 1'b1, 1'b0, 1'b0, 32'h0);
        run_random_phase(32'h8000_0000, RX_BURSTY, 1'b1, 1'b0, 1'b1, 32'hFFFF_FF80);
        run_random_phase(32'hFFFF_FFFF, RX_PERIODIC, 1'b1, 1'b0, 1'b0, 32'h0);
        run_random_phase($urandom, RX_ALWAYS, 1'b0, 1'b0, 1'b0, 32'h0);
        run_random_phase($urandom, RX_COIN, 1'b1, 1'b1, 1'b1, $urandom);
        run_random_phase($urandom_range(1, 4096), RX_BURSTY, 1'b1, 1'b0, 1'b1, $urandom);
        run_random_phase($urandom, RX_PERIODIC, 1'b0, 1'b1, 1'b0, 32'h0);
    endtask

    initial
    begin
        for (int k = 0; k <= TAB_N; k++)
        begin
            quarter_wave[k] = sine_point(longint'(k));
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_quadrant_corners();
        test_product_wrap();
        test_random_traffic();

        rx_mode = RX_ALWAYS;
        drain_pipeline();
        repeat (10) @(posedge clk);

        $display("Sent %0d samples under %0d phase_step settings; %0d beats checked.",
                 samples_sent, step_settings, results_checked);
        $display("Covered all quadrants, index wrap, sample extremes and output stalls.");
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, pending_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
